// ===== design/crs_pkg.sv =====
// Shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies; imported by the controller, the datapath and the top level.
package crs_pkg;

  // Default depth of the control point store
  localparam int MAX_POINTS_DEF = 64;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [6:0] PCOUNT_RST = 7'd4;

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Accumulator and product widths of the Horner unit
  localparam int ACC_W = 40;
  localparam int LOC_W = 17;
  localparam int PROD_W = ACC_W + LOC_W + 1;

  typedef struct packed {
    logic        operation;
    logic [5:0]  point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] t_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
    logic [5:0]  segment_number;
  } out_word_t;

  // Coefficient added after each Horner multiply
  typedef enum logic [1:0] {
    SEL_C2,
    SEL_C1,
    SEL_C0,
    SEL_C2X2
  } coef_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       mem_we;
    logic       in_load;
    logic       scale_en;
    logic       seg_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       coef_en;
    logic [1:0] axis;
    logic       acc_pos_init;
    logic       acc_der_init;
    logic       mul_en;
    logic       add_en;
    coef_sel_t  add_sel;
    logic       pos_en;
    logic       der_en;
    logic       out_load;
  } crs_cmd_t;

endpackage

// ===== design/crs_ctrl.sv =====
// Controller of the spline evaluator: sequences segment lookup, point reads
// and the Horner steps of each axis. Depends on crs_pkg.
module crs_ctrl
  import crs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output crs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SEG,
    S_READ,
    S_CALC,
    S_DONE
  } state_t;

  localparam logic [3:0] MS_LAST = 4'd13;
  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [2:0] RD_LAST = 3'd4;

  state_t     state;
  logic [2:0] cnt;
  logic [3:0] ms;
  logic [1:0] axis;
  logic       accept;
  logic       out_go;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_go = (state == S_DONE) && (!out_valid || out_ready);

  // Advance state, counters and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ms <= '0;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_op == OP_EVAL) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_SEG;
        S_SEG: begin
          state <= S_READ;
          cnt <= '0;
        end
        S_READ: begin
          cnt <= cnt + 3'd1;
          if (cnt == RD_LAST) begin
            state <= S_CALC;
            ms <= '0;
            axis <= '0;
          end
        end
        S_CALC: begin
          if (ms == MS_LAST) begin
            ms <= '0;
            if (axis == AXIS_LAST) begin
              state <= S_DONE;
            end else begin
              axis <= axis + 2'd1;
            end
          end else begin
            ms <= ms + 4'd1;
          end
        end
        S_DONE: begin
          if (out_go) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode datapath commands from state and step counters
  always_comb begin
    cmd = '0;
    cmd.add_sel = SEL_C2;
    cmd.mem_we = accept && in_op == OP_WRITE;
    cmd.in_load = accept && in_op == OP_EVAL;
    cmd.scale_en = (state == S_SCALE);
    cmd.seg_en = (state == S_SEG);
    cmd.out_load = out_go;
    cmd.axis = axis;
    cmd.rd_sel = cnt[1:0];
    cmd.cap_sel = 2'(cnt - 3'd1);
    if (state == S_READ) begin
      cmd.rd_en = (cnt != RD_LAST);
      cmd.cap_en = (cnt != 3'd0);
    end
    if (state == S_CALC) begin
      unique case (ms)
        4'd0: cmd.coef_en = 1'b1;
        4'd1: cmd.acc_pos_init = 1'b1;
        4'd2, 4'd4, 4'd6, 4'd9, 4'd11: cmd.mul_en = 1'b1;
        4'd3: begin
          cmd.add_en = 1'b1;
          cmd.add_sel = SEL_C2;
        end
        4'd5, 4'd12: begin
          cmd.add_en = 1'b1;
          cmd.add_sel = SEL_C1;
        end
        4'd7: begin
          cmd.add_en = 1'b1;
          cmd.add_sel = SEL_C0;
        end
        4'd8: begin
          cmd.pos_en = 1'b1;
          cmd.acc_der_init = 1'b1;
        end
        4'd10: begin
          cmd.add_en = 1'b1;
          cmd.add_sel = SEL_C2X2;
        end
        4'd13: cmd.der_en = 1'b1;
        default: cmd.mul_en = 1'b0;
      endcase
    end
  end

endmodule

// ===== design/crs_datapath.sv =====
// Datapath of the spline evaluator: point memory, configuration registers,
// segment mapping, coefficient build and shared Horner multiplier. Uses crs_pkg.
module crs_datapath
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crs_cmd_t              cmd,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_word_t             out_data
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int SC_W = LOC_W + NW;

  // Configuration registers
  logic       closed_loop;
  logic [6:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_loop <= 1'b0;
      point_count <= PCOUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOSED: closed_loop <= cfg_data[0];
        CFG_COUNT:  point_count <= cfg_data;
        default:    closed_loop <= closed_loop;
      endcase
    end
  end

  // Clamp the point count and derive the number of segments
  logic [NW-1:0] n;
  logic [NW-1:0] segs;

  always_comb begin
    if (point_count < 7'd4) begin
      n = NW'(4);
    end else if (int'(point_count) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(point_count);
    end
    segs = closed_loop ? n : n - NW'(3);
  end

  // Point memory, one word holds x, y and z
  logic [95:0]   mem [MAX_POINTS];
  logic [95:0]   rd_q;
  logic [IW-1:0] idx_q [4];

  always_ff @(posedge clk) begin
    if (cmd.mem_we && int'(in_data.point_index) < MAX_POINTS) begin
      mem[IW'(in_data.point_index)] <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[idx_q[cmd.rd_sel]];
    end
  end

  // Hold the parameter and map it onto a segment
  logic signed [31:0] t_q;
  logic [LOC_W-1:0]   tn;
  logic [SC_W-1:0]    scaled_q;

  always_comb begin
    if (closed_loop) begin
      tn = {1'b0, t_q[15:0]};
    end else if (t_q[31]) begin
      tn = '0;
    end else if (t_q > 32'sh0001_0000) begin
      tn = 17'h1_0000;
    end else begin
      tn = t_q[16:0];
    end
  end

  logic [NW:0]      seg_raw;
  logic [NW-1:0]    seg_w;
  logic [LOC_W-1:0] l_w;
  logic [NW:0]      s_ext;
  logic [NW:0]      n_ext;
  logic [NW:0]      nb [4];
  logic [IW-1:0]    seg_q;
  logic [LOC_W-1:0] l_q;

  always_comb begin
    seg_raw = scaled_q[SC_W-1:16];
    if (seg_raw > {1'b0, segs - NW'(1)}) begin
      seg_w = segs - NW'(1);
    end else begin
      seg_w = seg_raw[NW-1:0];
    end
    l_w = LOC_W'(scaled_q - (SC_W'(seg_w) << 16));
    s_ext = {1'b0, seg_w};
    n_ext = {1'b0, n};
    for (int k = 0; k < 4; k++) begin
      nb[k] = s_ext + (NW+1)'(k);
    end
    if (closed_loop) begin
      nb[0] = (seg_w == '0) ? n_ext - (NW+1)'(1) : s_ext - (NW+1)'(1);
      nb[1] = s_ext;
      for (int k = 2; k < 4; k++) begin
        if (s_ext + (NW+1)'(k - 1) >= n_ext) begin
          nb[k] = s_ext + (NW+1)'(k - 1) - n_ext;
        end else begin
          nb[k] = s_ext + (NW+1)'(k - 1);
        end
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (int'(nb[k]) > MAX_POINTS - 1) begin
          nb[k] = (NW+1)'(MAX_POINTS - 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      t_q <= in_data.t_value;
    end
    if (cmd.scale_en) begin
      scaled_q <= SC_W'(tn) * SC_W'(segs);
    end
    if (cmd.seg_en) begin
      seg_q <= IW'(seg_w);
      l_q <= l_w;
      for (int k = 0; k < 4; k++) begin
        idx_q[k] <= IW'(nb[k]);
      end
    end
  end

  // Capture the four neighbor points
  logic [95:0] p_q [4];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      p_q[cmd.cap_sel] <= rd_q;
    end
  end

  // Pick one axis of a point, sign extended
  function automatic logic signed [ACC_W-1:0] axis_pt(logic [95:0] pt, logic [1:0] ax);
    logic [31:0] v;
    case (ax)
      2'd0:    v = pt[95:64];
      2'd1:    v = pt[63:32];
      default: v = pt[31:0];
    endcase
    return ACC_W'($signed(v));
  endfunction

  // Halve with rounding half up, then saturate to 32 bits
  function automatic logic [31:0] halve_sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] h;
    h = (a + ACC_W'(1)) >>> 1;
    if (h[ACC_W-1:31] != '0 && h[ACC_W-1:31] != '1) begin
      return h[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return h[31:0];
  endfunction

  // Build coefficients of the current axis
  logic signed [ACC_W-1:0] a0, a1, a2, a3;
  logic signed [ACC_W-1:0] c0_q, c1_q, c2_q, c3_q;

  assign a0 = axis_pt(p_q[0], cmd.axis);
  assign a1 = axis_pt(p_q[1], cmd.axis);
  assign a2 = axis_pt(p_q[2], cmd.axis);
  assign a3 = axis_pt(p_q[3], cmd.axis);

  always_ff @(posedge clk) begin
    if (cmd.coef_en) begin
      c0_q <= a1 <<< 1;
      c1_q <= a2 - a0;
      c2_q <= (a0 <<< 1) - ((a1 <<< 2) + a1) + (a2 <<< 2) - a3;
      c3_q <= ((a1 <<< 1) + a1) - ((a2 <<< 1) + a2) + a3 - a0;
    end
  end

  // Horner unit: multiply, then round, shift and add a coefficient
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  coef;

  always_comb begin
    case (cmd.add_sel)
      SEL_C2:   coef = c2_q;
      SEL_C1:   coef = c1_q;
      SEL_C0:   coef = c0_q;
      SEL_C2X2: coef = c2_q <<< 1;
      default:  coef = c2_q;
    endcase
    rnd = (prod_q + $signed(PROD_W'(17'h0_8000))) >>> 16;
  end

  logic [31:0] res_pos [3];
  logic [31:0] res_der [3];

  always_ff @(posedge clk) begin
    if (cmd.acc_pos_init) begin
      acc_q <= c3_q;
    end else if (cmd.acc_der_init) begin
      acc_q <= (c3_q <<< 1) + c3_q;
    end else if (cmd.add_en) begin
      acc_q <= ACC_W'(rnd) + coef;
    end
    if (cmd.mul_en) begin
      prod_q <= acc_q * $signed({1'b0, l_q});
    end
    if (cmd.pos_en) begin
      res_pos[cmd.axis] <= halve_sat(acc_q);
    end
    if (cmd.der_en) begin
      res_der[cmd.axis] <= halve_sat(acc_q);
    end
  end

  // Output register, loaded once the previous word is taken
  out_word_t out_q;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q.pos_x <= res_pos[0];
      out_q.pos_y <= res_pos[1];
      out_q.pos_z <= res_pos[2];
      out_q.deriv_x <= res_der[0];
      out_q.deriv_y <= res_der[1];
      out_q.deriv_z <= res_der[2];
      out_q.segment_number <= 6'(seg_q);
    end
  end

  assign out_data = out_q;

endmodule

// ===== design/catmull_rom_spline_evaluator_top.sv =====
// Top level of the uniform Catmull-Rom spline evaluator.
// Instantiates crs_ctrl and crs_datapath; uses crs_pkg.

// A write word stores one control point and gives no result. An evaluate
// word scales t, finds the segment, fetches the four neighbor points through
// the single read port of the point memory, and then for each axis builds
// the coefficients and runs the Horner steps of position and derivative on
// one shared multiplier. A new word is taken while a finished result still
// waits on the output register. Configuration writes take effect at once and
// must be made while the block is idle.
module catmull_rom_spline_evaluator_top
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  crs_cmd_t cmd;

  assign cfg_ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  crs_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // An evaluate word blocks the input until its result is built
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.operation == OP_EVAL) |=> !in_ready)
    else $error("input taken during evaluation");

  // A write word never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.operation == OP_WRITE && !out_valid) |=> !out_valid)
    else $error("result raised by a write word");

  // A result is loaded only from the done step, never while idle
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !in_ready)
    else $error("output loaded while idle");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Catmull-Rom spline evaluator top level.
// Depends on crs_pkg and catmull_rom_spline_evaluator_top; a scoreboard class
// predicts each evaluate word, and plain tasks drive the input and configuration channels.
module testbench;
  import crs_pkg::*;

  localparam int NPTS = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 120;

  // Predicts spline results and holds the ones still to arrive
  class spline_scoreboard;
    logic [31:0] px[NPTS];
    logic [31:0] py[NPTS];
    logic [31:0] pz[NPTS];
    bit closed;
    logic [6:0] count;
    out_word_t pending[$];

    function new();
      for (int i = 0; i < NPTS; i++) begin
        px[i] = '0;
        py[i] = '0;
        pz[i] = '0;
      end
      closed = 0;
      count = PCOUNT_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_CLOSED) closed = val[0];
      else if (idx == CFG_COUNT) count = val;
    endfunction

    function longint hstep(longint acc, longint loc, longint c);
      return ((acc * loc + 64'sh8000) >>> 16) + c;
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    // Evaluate one axis: position and derivative
    function void axis(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                       longint loc, output logic [31:0] pos, output logic [31:0] der);
      longint p0, p1, p2, p3, c0, c1, c2, c3, acc;
      p0 = longint'(signed'(a));
      p1 = longint'(signed'(b));
      p2 = longint'(signed'(c));
      p3 = longint'(signed'(d));
      c0 = 2 * p1;
      c1 = p2 - p0;
      c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c3 = -p0 + 3 * p1 - 3 * p2 + p3;
      acc = hstep(hstep(hstep(c3, loc, c2), loc, c1), loc, c0);
      pos = sat((acc + 1) >>> 1);
      acc = hstep(hstep(3 * c3, loc, 2 * c2), loc, c1);
      der = sat((acc + 1) >>> 1);
    endfunction

    // Note an accepted input word
    function void note_input(in_word_t w);
      int n, segs, seg;
      int idx[4];
      longint tn, scaled, loc;
      out_word_t e;
      if (w.operation == OP_WRITE) begin
        px[w.point_index] = w.coord_x;
        py[w.point_index] = w.coord_y;
        pz[w.point_index] = w.coord_z;
        return;
      end
      n = count;
      if (n < 4) n = 4;
      if (n > NPTS) n = NPTS;
      segs = closed ? n : n - 3;
      if (closed) tn = longint'(w.t_value[15:0]);
      else begin
        tn = longint'(w.t_value);
        if (tn < 0) tn = 0;
        if (tn > 64'sh10000) tn = 64'sh10000;
      end
      scaled = tn * segs;
      seg = int'(scaled >>> 16);
      if (seg > segs - 1) seg = segs - 1;
      loc = scaled - (longint'(seg) <<< 16);
      for (int k = 0; k < 4; k++) begin
        idx[k] = closed ? (seg + n - 1 + k) % n : seg + k;
        if (idx[k] >= NPTS) idx[k] = NPTS - 1;
      end
      axis(px[idx[0]], px[idx[1]], px[idx[2]], px[idx[3]], loc, e.pos_x, e.deriv_x);
      axis(py[idx[0]], py[idx[1]], py[idx[2]], py[idx[3]], loc, e.pos_y, e.deriv_y);
      axis(pz[idx[0]], pz[idx[1]], pz[idx[2]], pz[idx[3]], loc, e.pos_z, e.deriv_z);
      e.segment_number = seg[5:0];
      pending = {pending, e};
    endfunction

    // Check a result against the oldest expectation; returns mismatch text
    function string check_result(out_word_t g);
      out_word_t e;
      string s;
      if (pending.size() == 0) return $sformatf("unexpected result %h", g);
      e = pending.pop_front();
      s = "";
      if (g.pos_x !== e.pos_x) s = {s, $sformatf(" pos_x %h/%h", g.pos_x, e.pos_x)};
      if (g.pos_y !== e.pos_y) s = {s, $sformatf(" pos_y %h/%h", g.pos_y, e.pos_y)};
      if (g.pos_z !== e.pos_z) s = {s, $sformatf(" pos_z %h/%h", g.pos_z, e.pos_z)};
      if (g.deriv_x !== e.deriv_x) s = {s, $sformatf(" der_x %h/%h", g.deriv_x, e.deriv_x)};
      if (g.deriv_y !== e.deriv_y) s = {s, $sformatf(" der_y %h/%h", g.deriv_y, e.deriv_y)};
      if (g.deriv_z !== e.deriv_z) s = {s, $sformatf(" der_z %h/%h", g.deriv_z, e.deriv_z)};
      if (g.segment_number !== e.segment_number)
        s = {s, $sformatf(" seg %0d/%0d", g.segment_number, e.segment_number)};
      return s;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spline_scoreboard sb;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;

  catmull_rom_spline_evaluator_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task report(string msg);
    $display("MISMATCH at cycle %0d:%s", cycles, msg);
    errors++;
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure with a quiet window
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (cycles > 30000 && cycles < 50000) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 14);
  end

  // Check every accepted result word
  always @(posedge clk) begin
    string s;
    if (!rst && out_valid && out_ready) begin
      s = sb.check_result(out_data);
      if (s != "") report(s);
    end
  end

  // Send one input word, idling first at random
  task send_word(in_word_t w);
    if (!(items_sent > 500 && items_sent < 800)) begin
      while ($urandom_range(99) < 14) begin
        @(negedge clk);
        in_valid <= 0;
      end
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    items_sent++;
  endtask

  // Wait for the block to drain, then write one register
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function in_word_t point_word(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w = '0;
    w.operation = OP_WRITE;
    w.point_index = idx[5:0];
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    w.t_value = $urandom;
    return w;
  endfunction

  function in_word_t eval_word(logic [31:0] t);
    in_word_t w;
    w.operation = OP_EVAL;
    w.point_index = 6'($urandom);
    w.coord_x = $urandom;
    w.coord_y = $urandom;
    w.coord_z = $urandom;
    w.t_value = t;
    return w;
  endfunction

  function logic [31:0] rand_t();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h10000);
      2: return {16'($urandom_range(3)), 16'($urandom)};
      3: return ($urandom_range(64) * 32'h10000) / 61 + $urandom_range(2) - 1;
      default: return $urandom_range(32'h10000) - 32'h8000;
    endcase
  endfunction

  initial begin
    logic [6:0] counts[8];
    bit modes[8];
    in_word_t w;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Fill every entry so no unwritten point is ever read
    for (int i = 0; i < NPTS; i++) begin
      if (i < 4)
        send_word(point_word(i, i[0] ? 32'h7fffffff : 32'h80000000,
                             i[1] ? 32'h80000000 : 32'h7fffffff, i[0] ? 32'h0 : 32'hffffffff));
      else send_word(point_word(i, rand_coord(), rand_coord(), rand_coord()));
    end

    // Directed evaluates at reset config: extremes and the end of the path
    send_word(eval_word(32'h0));
    send_word(eval_word(32'h10000));
    send_word(eval_word(32'h80000000));
    send_word(eval_word(32'h7fffffff));
    send_word(eval_word(32'h8000));
    send_word(eval_word(32'hffff));
    write_reg(CFG_CLOSED, 7'd1);
    send_word(eval_word(32'h0));
    send_word(eval_word(32'hffff));
    send_word(eval_word(32'hffffffff));
    send_word(eval_word(32'h80000000));
    // Out-of-range count and ignored register indexes
    write_reg(CFG_COUNT, 7'd127);
    send_word(eval_word(32'hc000));
    write_reg(2'd2, 7'h7f);
    write_reg(2'd3, 7'h7f);
    send_word(eval_word(32'hffff));
    write_reg(CFG_COUNT, 7'd0);
    send_word(eval_word(32'hffff));

    // Random phases over several settings
    modes = '{0, 1, 0, 1, 0, 1, 0, 1};
    counts = '{7'd4, 7'd64, 7'd64, 7'd4, 7'd5, 7'd7,
               7'($urandom_range(64, 4)), 7'($urandom_range(64, 4))};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_CLOSED, 7'(modes[ph]));
      write_reg(CFG_COUNT, counts[ph]);
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(99) < 30)
          w = point_word($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
        else w = eval_word(rand_t());
        send_word(w);
      end
    end

    // Drain and finish
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
